// ----- sv/huffman_code_builder_assert.svh -----
// assertion macros shared by the huffman code builder checker
// no dependencies; callers pass clock, active-low reset, condition and message
`ifndef HUFFMAN_CODE_BUILDER_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_ASSERT_SVH

// same-cycle implication
`define HCB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hcb_pkg.sv -----
// shared constants and types of the huffman code builder
// no dependencies
package hcb_pkg;

    localparam int MAX_SYMBOLS = 32;
    localparam int SYMBOL_W    = 8;
    localparam int IN_WEIGHT_W = 16;
    localparam int WEIGHT_W    = 21;
    localparam int CODE_W      = 31;
    localparam int LEN_W       = 5;
    localparam int POS_W       = 5;
    localparam int MIN_TREE    = 3;

    // control from the sequencer to the two-smallest tracker
    typedef struct packed {
        logic clear;
        logic sample;
    } t_scan_ctl;

endpackage

// ----- sv/hcb_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/hcb_min2.sv -----
// tracker of the two smallest parentless nodes seen during one node scan
// depends on hcb_pkg; ties keep the lower node index since nodes arrive in order
module hcb_min2 #(
    parameter int IDX_W = 6,
    parameter int AUX_W = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hcb_pkg::t_scan_ctl        i_ctl,
    input  logic [IDX_W-1:0]          i_idx,
    input  logic [hcb_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [AUX_W-1:0]          i_aux,
    output logic [IDX_W-1:0]          o_a_idx,
    output logic [hcb_pkg::WEIGHT_W-1:0] o_a_weight,
    output logic [AUX_W-1:0]          o_a_aux,
    output logic [IDX_W-1:0]          o_b_idx,
    output logic [hcb_pkg::WEIGHT_W-1:0] o_b_weight,
    output logic [AUX_W-1:0]          o_b_aux
);

    logic                         r_a_vld, r_b_vld;
    logic [IDX_W-1:0]             r_a_idx, r_b_idx;
    logic [hcb_pkg::WEIGHT_W-1:0] r_a_w, r_b_w;
    logic [AUX_W-1:0]             r_a_aux, r_b_aux;
    logic                         take_a, take_b;

    // strict compares so an equal weight never displaces an earlier node
    assign take_a = i_ctl.sample && (!r_a_vld || (i_weight < r_a_w));
    assign take_b = i_ctl.sample && !take_a && (!r_b_vld || (i_weight < r_b_w));

    // candidate valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (take_a) begin
            r_a_vld <= 1'b1;
            r_b_vld <= r_a_vld;
        end else if (take_b) begin
            r_b_vld <= 1'b1;
        end
    end

    // candidate payload
    always_ff @(posedge i_clk) begin
        if (take_a) begin
            r_b_idx <= r_a_idx;
            r_b_w   <= r_a_w;
            r_b_aux <= r_a_aux;
            r_a_idx <= i_idx;
            r_a_w   <= i_weight;
            r_a_aux <= i_aux;
        end else if (take_b) begin
            r_b_idx <= i_idx;
            r_b_w   <= i_weight;
            r_b_aux <= i_aux;
        end
    end

    assign o_a_idx    = r_a_idx;
    assign o_a_weight = r_a_w;
    assign o_a_aux    = r_a_aux;
    assign o_b_idx    = r_b_idx;
    assign o_b_weight = r_b_w;
    assign o_b_aux    = r_b_aux;

endmodule

// ----- sv/huffman_code_builder.sv -----
// Huffman code builder. Load accepts a request whenever start is high while busy is low;
// the request with last set starts construction and busy stays high until the last
// code has been strobed. All tree state sits in one node ram (one read and one write
// port, registered read), so the ram port sets the pace: building internal node m
// scans nodes 0..m-1 one per cycle, drains the read pipeline and then writes the
// parent field of both chosen children and the new node itself; emitting a code
// reads the leaf, then walks its parents up to the root. Fewer than three symbols
// skip construction. Codes come out on single-cycle o_valid strobes in load order and
// the receiver cannot stall them.
// Depends on hcb_pkg, hcb_ram and hcb_min2.
module huffman_code_builder #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [hcb_pkg::SYMBOL_W-1:0]    i_symbol,
    input  logic [hcb_pkg::IN_WEIGHT_W-1:0] i_weight,
    input  logic                           i_last,
    output logic                           o_valid,
    output logic [hcb_pkg::POS_W-1:0]      o_leaf_position,
    output logic [hcb_pkg::SYMBOL_W-1:0]    o_symbol_out,
    output logic [hcb_pkg::CODE_W-1:0]     o_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]      o_code_length,
    output logic                           o_last_code
);

    localparam int NODES  = 2 * MAX_SYMBOLS - 1;
    localparam int NW     = $clog2(NODES);
    localparam int CW     = $clog2(MAX_SYMBOLS + 1);
    localparam int AUX_W  = hcb_pkg::SYMBOL_W;
    localparam int WW     = hcb_pkg::WEIGHT_W;
    localparam int WORD_W = NW + WW + AUX_W;
    localparam logic [NW-1:0] NO_PARENT = '1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_WR_A   = 9'b000000100,
        S_WR_B   = 9'b000001000,
        S_WR_N   = 9'b000010000,
        S_E_RD   = 9'b000100000,
        S_E_LEAF = 9'b001000000,
        S_E_WALK = 9'b010000000,
        S_E_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [NW-1:0] r_node, n_node;
    logic [NW-1:0] r_j, n_j;
    logic          r_pend, n_pend;
    logic [NW-1:0] r_pidx;
    logic [CW-1:0] r_k, n_k;
    logic [NW-1:0] r_cur, n_cur;
    logic [NW-1:0] r_p, n_p;
    logic [hcb_pkg::CODE_W-1:0] r_code, n_code;
    logic [hcb_pkg::LEN_W-1:0]  r_len, n_len;
    logic [AUX_W-1:0]           r_sym, n_sym;

    logic              accept;
    logic [CW-1:0]     load_cnt;
    logic [CW:0]       last_node_w;
    logic [NW-1:0]     last_node;
    logic              is_last_code;

    logic              ram_we;
    logic [NW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [NW-1:0]     rd_parent;
    logic [WW-1:0]     rd_weight;
    logic [AUX_W-1:0]  rd_aux;

    hcb_pkg::t_scan_ctl scan_ctl;
    logic [NW-1:0]    a_idx, b_idx;
    logic [WW-1:0]    a_w, b_w;
    logic [AUX_W-1:0] a_aux, b_aux;
    logic [WW-1:0]    sum_w;

    // node word: parent, weight, symbol for a leaf or left child for an internal node
    assign rd_aux    = ram_rdata[AUX_W-1:0];
    assign rd_weight = ram_rdata[AUX_W +: WW];
    assign rd_parent = ram_rdata[AUX_W+WW +: NW];

    assign accept      = start && !busy;
    assign load_cnt    = (r_count < CW'(MAX_SYMBOLS)) ? (r_count + 1'b1) : r_count;
    assign last_node_w = {r_count, 1'b0} - (CW+1)'(2);
    assign last_node   = NW'(last_node_w);
    assign is_last_code = ((r_k + 1'b1) == r_count);
    assign sum_w       = a_w + b_w;

    hcb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // scan control for the two-smallest tracker
    assign scan_ctl.clear  = accept || (r_state == S_WR_N);
    assign scan_ctl.sample = (r_state == S_SCAN) && r_pend && (rd_parent == NO_PARENT);

    hcb_min2 #(
        .IDX_W (NW),
        .AUX_W (AUX_W)
    ) u_min2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_idx      (r_pidx),
        .i_weight   (rd_weight),
        .i_aux      (rd_aux),
        .o_a_idx    (a_idx),
        .o_a_weight (a_w),
        .o_a_aux    (a_aux),
        .o_b_idx    (b_idx),
        .o_b_weight (b_w),
        .o_b_aux    (b_aux)
    );

    // ram write port: leaf load and merge write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        case (r_state)
            S_IDLE: begin
                ram_we    = accept && (r_count < CW'(MAX_SYMBOLS));
                ram_waddr = NW'(r_count);
                ram_wdata = {NO_PARENT, WW'(i_weight), i_symbol};
            end
            S_WR_A: begin
                ram_we    = 1'b1;
                ram_waddr = a_idx;
                ram_wdata = {r_node, a_w, a_aux};
            end
            S_WR_B: begin
                ram_we    = 1'b1;
                ram_waddr = b_idx;
                ram_wdata = {r_node, b_w, b_aux};
            end
            S_WR_N: begin
                ram_we    = 1'b1;
                ram_waddr = r_node;
                ram_wdata = {NO_PARENT, sum_w, AUX_W'(a_idx)};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ram read address
    always_comb begin
        case (r_state)
            S_SCAN:   ram_raddr = r_j;
            S_E_RD:   ram_raddr = NW'(r_k);
            S_E_LEAF: ram_raddr = rd_parent;
            S_E_WALK: ram_raddr = rd_parent;
            default:  ram_raddr = '0;
        endcase
    end

    // sequencer: load, merge loop, code walk
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_node  = r_node;
        n_j     = r_j;
        n_pend  = 1'b0;
        n_k     = r_k;
        n_cur   = r_cur;
        n_p     = r_p;
        n_code  = r_code;
        n_len   = r_len;
        n_sym   = r_sym;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_count = load_cnt;
                    if (i_last) begin
                        n_k = '0;
                        if (load_cnt >= CW'(hcb_pkg::MIN_TREE)) begin
                            n_node  = NW'(load_cnt);
                            n_j     = '0;
                            n_state = S_SCAN;
                        end else begin
                            n_state = S_E_RD;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_j < r_node) begin
                    n_j    = r_j + 1'b1;
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_state = S_WR_A;
                end
            end
            S_WR_A: n_state = S_WR_B;
            S_WR_B: n_state = S_WR_N;
            S_WR_N: begin
                if (r_node == last_node) begin
                    n_state = S_E_RD;
                end else begin
                    n_node  = r_node + 1'b1;
                    n_j     = '0;
                    n_state = S_SCAN;
                end
            end
            S_E_RD: n_state = S_E_LEAF;
            S_E_LEAF: begin
                n_sym  = rd_aux;
                n_cur  = NW'(r_k);
                n_p    = rd_parent;
                n_code = '0;
                n_len  = '0;
                n_state = (rd_parent == NO_PARENT) ? S_E_OUT : S_E_WALK;
            end
            S_E_WALK: begin
                // bit is 0 when we came up from the left child
                n_code = r_code | (hcb_pkg::CODE_W'(rd_aux[NW-1:0] != r_cur) << r_len);
                n_len  = r_len + 1'b1;
                n_cur  = r_p;
                n_p    = rd_parent;
                if ((rd_parent == NO_PARENT) ||
                    (r_len == hcb_pkg::LEN_W'(hcb_pkg::CODE_W - 1))) begin
                    n_state = S_E_OUT;
                end
            end
            S_E_OUT: begin
                n_k = r_k + 1'b1;
                if (is_last_code) begin
                    n_count = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_E_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_j    <= n_j;
        r_pidx <= r_j;
        r_k    <= n_k;
        r_cur  <= n_cur;
        r_p    <= n_p;
        r_code <= n_code;
        r_len  <= n_len;
        r_sym  <= n_sym;
    end

    // outputs
    assign busy            = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_E_OUT);
    assign o_leaf_position = hcb_pkg::POS_W'(r_k);
    assign o_symbol_out    = r_sym;
    assign o_code_bits     = r_code;
    assign o_code_length   = r_len;
    assign o_last_code     = is_last_code;

endmodule

// ----- sv/hcb_checker.sv -----
// port-level checks of the huffman code builder, bound to the top level
// depends on huffman_code_builder_assert.svh and huffman_code_builder
`include "huffman_code_builder_assert.svh"

module hcb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last,
    input logic o_valid,
    input logic o_last_code
);

    // a final request raises busy (construction, or the code walk for fewer than three symbols)
    `HCB_ASSERT_NXT(a_last_starts, i_clk, i_rst_n, start && !busy && i_last, busy, "last request did not raise busy")
    // a plain load request returns straight to idle
    `HCB_ASSERT_NXT(a_load_idle, i_clk, i_rst_n, start && !busy && !i_last, !busy, "load request left the block busy")
    // codes only appear while busy
    `HCB_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, busy, "code strobe while idle")
    // the final code closes the set
    `HCB_ASSERT_NXT(a_last_done, i_clk, i_rst_n, o_valid && o_last_code, !busy && !o_valid, "block still busy after final code")

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_last      (i_last),
    .o_valid     (o_valid),
    .o_last_code (o_last_code)
);
